/* rtl/core/three_mic_arrival_timer_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the three-microphone arrival timer
// Shared property wrappers, clocked on aclk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef THREE_MIC_ARRIVAL_TIMER_UNIT_DEFINES_SVH
`define THREE_MIC_ARRIVAL_TIMER_UNIT_DEFINES_SVH

// same-cycle implication
`define TMAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TMAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tmat_pkg.sv */
// ---------------------------------------------------------------------------
// tmat_pkg
// Types, codes and helpers shared by the arrival timer modules.
// ---------------------------------------------------------------------------
package tmat_pkg;

    localparam int MIC_N     = 3;
    localparam int CNT_W     = 32;
    localparam int ID_W      = 2;
    localparam int PHASE_W   = 2;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    // capture phase codes
    localparam logic [PHASE_W-1:0] PH_WAIT   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SECOND = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DONE   = 2'd3;

    localparam logic [MIC_N-1:0] ARMED_ALL     = '1;
    localparam logic [CNT_W-1:0] COUNT_MAX     = '1;
    localparam logic [CNT_W-1:0] TIMEOUT_RESET = 32'd200000000;
    localparam logic [ID_W-1:0]  ID_NONE       = '0;

    typedef struct packed {
        logic [MIC_N-1:0] mic_edges;
        logic             rearm;
    } item_t;

    typedef struct packed {
        logic             capture_done;
        logic             timed_out;
        logic [ID_W-1:0]  first_mic_id;
        logic [ID_W-1:0]  second_mic_id;
        logic [ID_W-1:0]  third_mic_id;
        logic [CNT_W-1:0] delay_to_second;
        logic [CNT_W-1:0] delay_to_third;
    } result_t;

    // saturating tick counter step
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

/* rtl/core/three_mic_arrival_timer_unit.sv */
// ---------------------------------------------------------------------------
// three_mic_arrival_timer_unit
// Arrival order and inter-arrival tick counts for a three-microphone array.
// ---------------------------------------------------------------------------
// Each s_ beat is one timing tick: s_tdata[2:0] holds the edge bits of
// microphones 1..3, s_tuser the re-arm strobe. Every beat yields exactly one
// m_ beat with the capture state at the end of that tick: arrival order ids,
// the two delay counts, and the capture_done / timed_out flags in m_tuser.
// The cfg_ channel loads the timeout in ticks; write it only while idle.
// Throughput is one beat per cycle while m_tready is high: the capture state
// is updated in a single pass between the input register and the result
// register, so each accepted beat goes from the input register to the result register.
// A stalled m_ side holds the result register; the input register then
// fills and s_tready drops in the same cycle, so no beat is lost.
// s_tready follows m_tready combinationally through the two registers.
// Reset (aresetn low, synchronous) arms all microphones, clears the order
// and counters, empties both registers and restores the default timeout
// of 200000000 ticks.
// ---------------------------------------------------------------------------
`include "three_mic_arrival_timer_unit_defines.svh"

module three_mic_arrival_timer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tmat_pkg::S_TDATA_W-1:0] s_tdata,   // [2:0] mic_edges, rest zero
    input  logic                           s_tuser,   // [0] rearm
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] first_mic_id, [3:2] second_mic_id, [5:4] third_mic_id,
    // [37:6] delay_to_second, [69:38] delay_to_third, [71:70] zero
    output logic [tmat_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [tmat_pkg::M_TUSER_W-1:0] m_tuser,   // [0] capture_done, [1] timed_out
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmat_pkg::CNT_W-1:0]     cfg_data
);
    import tmat_pkg::*;

    item_t item;
    logic  item_valid;
    logic  item_take;

    tmat_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    tmat_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    `TMAT_ASSERT_NOW(a_done_xor_timeout, m_tvalid, !(m_tuser[0] && m_tuser[1]), "done and timeout together")
    `TMAT_ASSERT_NOW(a_done_has_third, m_tvalid && m_tuser[0], m_tdata[5:4] != ID_NONE, "done without third id")
    `TMAT_ASSERT_NOW(a_timeout_clears, m_tvalid && m_tuser[1], m_tdata == '0, "timeout left capture state")
    `TMAT_ASSERT_NOW(a_stall_backpressure, m_tvalid && !m_tready && item_valid, !s_tready, "input taken while full and stalled")

endmodule

/* rtl/core/tmat_in_reg.sv */
// ---------------------------------------------------------------------------
// tmat_in_reg
// Input register stage: captures one beat and holds it until the core takes it.
// ---------------------------------------------------------------------------
module tmat_in_reg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tmat_pkg::S_TDATA_W-1:0] s_tdata,   // [2:0] mic_edges, rest zero
    input  logic                          s_tuser,   // [0] rearm
    output tmat_pkg::item_t               item,
    output logic                          item_valid,
    input  logic                          item_take
);
    import tmat_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.mic_edges <= s_tdata[MIC_N-1:0];
            item_reg.rearm     <= s_tuser;
        end
    end

endmodule

/* rtl/core/tmat_core.sv */
// ---------------------------------------------------------------------------
// tmat_core
// Capture state, per-tick update logic and the result register.
// ---------------------------------------------------------------------------
module tmat_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tmat_pkg::item_t                item,
    input  logic                           item_valid,
    output logic                           item_take,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmat_pkg::CNT_W-1:0]     cfg_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] first_mic_id, [3:2] second_mic_id, [5:4] third_mic_id,
    // [37:6] delay_to_second, [69:38] delay_to_third, [71:70] zero
    output logic [tmat_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [tmat_pkg::M_TUSER_W-1:0] m_tuser    // [0] capture_done, [1] timed_out
);
    import tmat_pkg::*;

    logic [CNT_W-1:0]   timeout_reg;
    logic [PHASE_W-1:0] phase_reg,  phase_next;
    logic [MIC_N-1:0]   armed_reg,  armed_next;
    logic [ID_W-1:0]    ord0_reg,   ord0_next;
    logic [ID_W-1:0]    ord1_reg,   ord1_next;
    logic [ID_W-1:0]    ord2_reg,   ord2_next;
    logic [CNT_W-1:0]   cnt2_reg,   cnt2_next;
    logic [CNT_W-1:0]   cnt3_reg,   cnt3_next;
    logic               done_next,  tout_next;
    logic               out_valid_reg;
    result_t            res_reg;

    assign cfg_ready = 1'b1;
    assign item_take = item_valid && (!out_valid_reg || m_tready);

    always_comb begin
        phase_next = phase_reg;
        armed_next = armed_reg;
        ord0_next  = ord0_reg;
        ord1_next  = ord1_reg;
        ord2_next  = ord2_reg;
        cnt2_next  = cnt2_reg;
        cnt3_next  = cnt3_reg;
        done_next  = 1'b0;
        tout_next  = 1'b0;

        if (item.rearm) begin
            phase_next = PH_WAIT;
            armed_next = ARMED_ALL;
            ord0_next  = ID_NONE;
            ord1_next  = ID_NONE;
            ord2_next  = ID_NONE;
            cnt2_next  = '0;
            cnt3_next  = '0;
        end else if (phase_reg == PH_FIRST) begin
            cnt2_next = sat_inc(cnt2_reg);
            cnt3_next = sat_inc(cnt3_reg);
        end else if (phase_reg == PH_SECOND) begin
            cnt3_next = sat_inc(cnt3_reg);
        end

        // rank simultaneous edges mic 1, then 2, then 3
        for (int m = 0; m < MIC_N; m++) begin
            if (item.mic_edges[m] && armed_next[m] && phase_next != PH_DONE) begin
                armed_next[m] = 1'b0;
                case (phase_next)
                    PH_WAIT: begin
                        cnt2_next  = '0;
                        cnt3_next  = '0;
                        ord0_next  = ID_W'(m + 1);
                        phase_next = PH_FIRST;
                    end
                    PH_FIRST: begin
                        ord1_next  = ID_W'(m + 1);
                        phase_next = PH_SECOND;
                    end
                    default: begin
                        ord2_next  = ID_W'(m + 1);
                        phase_next = PH_DONE;
                        done_next  = 1'b1;
                    end
                endcase
            end
        end

        // abandon an open capture that has run too long
        if ((phase_next == PH_FIRST || phase_next == PH_SECOND) &&
            (cnt2_next > timeout_reg || cnt3_next > timeout_reg)) begin
            phase_next = PH_WAIT;
            armed_next = ARMED_ALL;
            ord0_next  = ID_NONE;
            ord1_next  = ID_NONE;
            ord2_next  = ID_NONE;
            cnt2_next  = '0;
            cnt3_next  = '0;
            tout_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= TIMEOUT_RESET;
            phase_reg     <= PH_WAIT;
            armed_reg     <= ARMED_ALL;
            ord0_reg      <= ID_NONE;
            ord1_reg      <= ID_NONE;
            ord2_reg      <= ID_NONE;
            cnt2_reg      <= '0;
            cnt3_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                timeout_reg <= cfg_data;
            end
            if (item_take) begin
                phase_reg     <= phase_next;
                armed_reg     <= armed_next;
                ord0_reg      <= ord0_next;
                ord1_reg      <= ord1_next;
                ord2_reg      <= ord2_next;
                cnt2_reg      <= cnt2_next;
                cnt3_reg      <= cnt3_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            res_reg.capture_done    <= done_next;
            res_reg.timed_out       <= tout_next;
            res_reg.first_mic_id    <= ord0_next;
            res_reg.second_mic_id   <= ord1_next;
            res_reg.third_mic_id    <= ord2_next;
            res_reg.delay_to_second <= cnt2_next;
            res_reg.delay_to_third  <= cnt3_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 3*ID_W - 2*CNT_W){1'b0}},
                       res_reg.delay_to_third, res_reg.delay_to_second,
                       res_reg.third_mic_id, res_reg.second_mic_id, res_reg.first_mic_id};
    assign m_tuser  = {res_reg.timed_out, res_reg.capture_done};

endmodule
